// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent must hold in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sts_pkg.sv
// shared constants and types of the sorted table search block
package sts_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W       = 10;
   localparam int CFG_W       = 11;
   localparam int DATA_W      = 32;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [ADDR_W-1:0]        rd_addr;
   } ram_req_type;

endpackage

// File: rtl/sts_channels.sv
// channel interfaces for requests, responses and the entry count register
interface sts_req_if;
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic [sts_pkg::IDX_W-1:0]         index;
   logic signed [sts_pkg::DATA_W-1:0] value;

   modport source (output valid, command, index, value, input ready);
   modport sink (input valid, command, index, value, output ready);
endinterface

interface sts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [sts_pkg::IDX_W-1:0]  position;

   modport source (output valid, found, position, input ready);
   modport sink (input valid, found, position, output ready);
endinterface

interface sts_csr_if;
   logic                       valid;
   logic                       ready;
   logic [sts_pkg::CFG_W-1:0]  entries_in_use;

   modport source (output valid, entries_in_use, input ready);
   modport sink (input valid, entries_in_use, output ready);
endinterface

// File: rtl/sts_table_ram.sv
// table memory: one write port, one read port with registered read data
module sts_table_ram (
   input  logic                                clock,
   input  sts_pkg::ram_req_type                ram_req,
   output logic signed [sts_pkg::DATA_W-1:0]   rd_data
);

   logic signed [sts_pkg::DATA_W-1:0] table_mem_ff [sts_pkg::TABLE_DEPTH];
   logic signed [sts_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         table_mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= table_mem_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sts_search_ctrl.sv
// search sequencer: accepts transactions, probes the table, holds the response
module sts_search_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sts_pkg::COUNT_W-1:0]        entry_count,
   sts_req_if.sink                            req_chan,
   sts_rsp_if.source                          rsp_chan,
   output sts_pkg::ram_req_type               ram_req,
   input  logic signed [sts_pkg::DATA_W-1:0]  rd_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PROBE  = 2'd1;
   localparam logic [1:0] ST_CMP    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [sts_pkg::COUNT_W-1:0]       lo_ff, lo_in;
   logic [sts_pkg::COUNT_W-1:0]       hix_ff, hix_in;
   logic [sts_pkg::ADDR_W-1:0]        mid_ff, mid_in;
   logic signed [sts_pkg::DATA_W-1:0] key_ff, key_in;
   logic                              res_found_ff, res_found_in;
   logic [sts_pkg::IDX_W-1:0]         res_pos_ff, res_pos_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [sts_pkg::IDX_W-1:0]         rsp_pos_ff, rsp_pos_in;

   logic                              req_fire;
   logic                              rsp_load;
   logic [sts_pkg::COUNT_W:0]         mid_sum;
   logic [sts_pkg::ADDR_W-1:0]        mid_calc;
   logic                              range_open;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_load       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // range is [lo, hix), middle rounded down
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hix_ff} - {{sts_pkg::COUNT_W{1'b0}}, 1'b1};
   assign mid_calc   = mid_sum[sts_pkg::ADDR_W:1];
   assign range_open = (lo_ff < hix_ff);

   always_comb begin
      ram_req.wr_en   = req_fire && (req_chan.command == sts_pkg::CMD_WRITE);
      ram_req.wr_addr = req_chan.index[sts_pkg::ADDR_W-1:0];
      ram_req.wr_data = req_chan.value;
      ram_req.rd_en   = (state_ff == ST_PROBE) && range_open;
      ram_req.rd_addr = mid_calc;
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hix_in       = hix_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.command == sts_pkg::CMD_SEARCH)) begin
               key_in   = req_chan.value;
               lo_in    = '0;
               hix_in   = entry_count;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (range_open) begin
               mid_in   = mid_calc;
               state_in = ST_CMP;
            end else begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               state_in     = ST_FINISH;
            end
         end
         ST_CMP: begin
            if (rd_data == key_ff) begin
               res_found_in = 1'b1;
               res_pos_in   = sts_pkg::IDX_W'(mid_ff);
               state_in     = ST_FINISH;
            end else begin
               if (rd_data > key_ff) begin
                  hix_in = sts_pkg::COUNT_W'(mid_ff);
               end else begin
                  lo_in = sts_pkg::COUNT_W'(mid_ff) + sts_pkg::COUNT_W'(1);
               end
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register lets the next transaction in while this one waits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_pos_in   = res_pos_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hix_ff       <= hix_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_pos_ff;

endmodule

// File: rtl/sorted_table_binary_search.sv
// a search runs PROBE and CMP for each probe, then FINISH; a hit leaves from CMP, a miss from PROBE
// each probe is one registered read of the table memory in PROBE and one compare in CMP
// up to 11 probes for 1024 entries; a new transaction is taken in the cycle after the response loads
// one search at a time: no request is taken until the sequencer is idle again; a write stays in idle
// reset clears the sequencer and sets entries_in_use to 1; table contents are kept
module sorted_table_binary_search (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_chan,
   sts_rsp_if.source rsp_chan,
   sts_csr_if.sink   csr_chan
);

   logic [sts_pkg::CFG_W-1:0]          entries_ff, entries_in;
   logic [sts_pkg::COUNT_W-1:0]        entry_count;
   sts_pkg::ram_req_type               ram_req;
   logic signed [sts_pkg::DATA_W-1:0]  rd_data;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      entries_in = entries_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         entries_in = csr_chan.entries_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= sts_pkg::CFG_W'(1);
      end else begin
         entries_ff <= entries_in;
      end
   end

   // counts above the table size search the whole table
   assign entry_count = (entries_ff > sts_pkg::CFG_W'(sts_pkg::TABLE_DEPTH)) ?
                        sts_pkg::COUNT_W'(sts_pkg::TABLE_DEPTH) :
                        sts_pkg::COUNT_W'(entries_ff);

   sts_search_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .entry_count (entry_count),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .ram_req     (ram_req),
      .rd_data     (rd_data)
   );

   sts_table_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// File: rtl/sts_checker.sv
// port-level checks of the search block, bound to the top level
`include "assert_macros.svh"

module sts_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_command,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_found,
   input logic [sts_pkg::IDX_W-1:0] rsp_position
);

   logic req_fire;
   logic rsp_stall;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_position), "stalled response changed")
   `ASSERT_SAME(a_miss_pos_zero, clock, reset, rsp_valid && !rsp_found, rsp_position == '0, "miss with nonzero position")
   `ASSERT_NEXT(a_write_no_rsp, clock, reset, req_fire && (req_command == sts_pkg::CMD_WRITE) && !rsp_valid, !rsp_valid, "write transaction produced a response")
   `ASSERT_NEXT(a_search_busy, clock, reset, req_fire && (req_command == sts_pkg::CMD_SEARCH), !req_ready, "request taken during a search")

endmodule

bind sorted_table_binary_search sts_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_command  (req_chan.command),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_found    (rsp_chan.found),
   .rsp_position (rsp_chan.position)
);
